@@ hw/rtl/grv_pkg.sv @@
package grv_pkg;

	localparam int CELL_SIZE_DEF = 64;
	localparam int MAP_CELLS_DEF = 32;

	localparam int PosW  = 19;
	localparam int AngW  = 12;
	localparam int CellW = 5;
	localparam int DistW = 20;
	localparam int CfgW  = 19;

	localparam int CordW = 34;
	localparam int TanW  = 29;
	localparam int QuoW  = 28;
	localparam int MulAW = 20;
	localparam int MulBW = 30;
	localparam int ProdW = 50;
	localparam int CrdW  = 32;
	localparam int SqW   = 40;
	localparam int ItW   = 5;

	localparam logic [ItW-1:0] CORDIC_LAST = 5'd23;
	localparam logic [ItW-1:0] DIV_LAST    = 5'd27;

	// 2048.0 in Q16.16
	localparam logic signed [TanW-1:0] TAN_LIM = 29'sd134217728;

	typedef enum logic [0:0] {
		REG_LIMIT_X = 1'b0,
		REG_LIMIT_Y = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WR_RD, ST_WR_WR, ST_CORDIC, ST_TAN_CHK, ST_DIV, ST_TAN_SET,
		ST_COL_EST, ST_COL_FIX, ST_MUL_NY, ST_RND_NY, ST_MUL_YS, ST_RND_YS,
		ST_STEP_A, ST_STEP_B, ST_STEP_C, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQRT, ST_DONE
	} grv_state_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_WR_RD, OP_WR_WR, OP_CORDIC, OP_TAN_CHK, OP_DIV, OP_TAN_SET,
		OP_COL_EST, OP_COL_FIX, OP_MUL_NY, OP_RND_NY, OP_MUL_YS, OP_RND_YS,
		OP_STEP_A, OP_STEP_B, OP_STEP_C, OP_SQ_X, OP_SQ_Y, OP_SQ_SUM, OP_SQRT, OP_HOLD
	} grv_op_t;

	typedef struct packed {
		logic wr_ok;
		logic it_last;
		logic tan_sat;
		logic in_bounds;
		logic wall;
		logic sq_last;
	} grv_status_t;

	// atan(2^-i) on a 2^32-per-turn scale
	function automatic logic [31:0] atan_val(input logic [ItW-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/grid_ray_vertical_hit.sv @@
// Channel   Handshake            Payload
// command   start / busy         kind pos_x pos_y angle cell_x cell_y wall
// result    done (1-cycle)       hit hit_x hit_y hit_distance
// config    cfg_we               cfg_index cfg_data
//
// A map write reads the row, then writes it back; an out-of-map write is dropped at once.
// A cast runs 24 CORDIC iterations, a restoring divide for tan unless tan saturates,
// then per cell step an estimate of the row, a map row read and a probe, then
// 20 square root iterations.
// Reset clears the limits to all ones and all map rows through per-row valid bits.
// done is high for one cycle; the receiver cannot stall it.
module grid_ray_vertical_hit #(
	parameter int CELL_SIZE = grv_pkg::CELL_SIZE_DEF,
	parameter int MAP_CELLS = grv_pkg::MAP_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [grv_pkg::PosW-1:0]      pos_x,
	input  logic [grv_pkg::PosW-1:0]      pos_y,
	input  logic [grv_pkg::AngW-1:0]      angle,
	input  logic [grv_pkg::CellW-1:0]     cell_x,
	input  logic [grv_pkg::CellW-1:0]     cell_y,
	input  logic                          wall,
	output logic                          done,
	output logic                          hit,
	output logic [grv_pkg::PosW-1:0]      hit_x,
	output logic [grv_pkg::PosW-1:0]      hit_y,
	output logic [grv_pkg::DistW-1:0]     hit_distance,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [grv_pkg::CfgW-1:0]      cfg_data
);

	grv_pkg::grv_op_t     op;
	grv_pkg::grv_status_t st;

	grv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.st     (st),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	grv_dp #(
		.CELL_SIZE (CELL_SIZE),
		.MAP_CELLS (MAP_CELLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.angle        (angle),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.wall         (wall),
		.hit          (hit),
		.hit_x        (hit_x),
		.hit_y        (hit_y),
		.hit_distance (hit_distance)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result transfer outside a cast");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_x == '0 && hit_y == '0 && hit_distance == '0))
		else $error("miss carries nonzero payload");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> (busy && !done))
		else $error("cast transfer did not start work");

endmodule

@@ hw/rtl/grv_ctrl.sv @@
module grv_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  kind,
	input  grv_pkg::grv_status_t  st,
	output grv_pkg::grv_op_t      op,
	output logic                  busy,
	output logic                  done
);

	grv_pkg::grv_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = grv_pkg::OP_HOLD;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			grv_pkg::ST_IDLE: begin
				op   = grv_pkg::OP_IDLE;
				busy = 1'b0;
				if (start) begin
					if (kind) begin
						state_d = grv_pkg::ST_CORDIC;
					end else if (st.wr_ok) begin
						state_d = grv_pkg::ST_WR_RD;
					end
				end
			end
			grv_pkg::ST_WR_RD: begin
				op      = grv_pkg::OP_WR_RD;
				state_d = grv_pkg::ST_WR_WR;
			end
			grv_pkg::ST_WR_WR: begin
				op      = grv_pkg::OP_WR_WR;
				state_d = grv_pkg::ST_IDLE;
			end
			grv_pkg::ST_CORDIC: begin
				op = grv_pkg::OP_CORDIC;
				if (st.it_last) state_d = grv_pkg::ST_TAN_CHK;
			end
			grv_pkg::ST_TAN_CHK: begin
				op      = grv_pkg::OP_TAN_CHK;
				state_d = st.tan_sat ? grv_pkg::ST_COL_EST : grv_pkg::ST_DIV;
			end
			grv_pkg::ST_DIV: begin
				op = grv_pkg::OP_DIV;
				if (st.it_last) state_d = grv_pkg::ST_TAN_SET;
			end
			grv_pkg::ST_TAN_SET: begin
				op      = grv_pkg::OP_TAN_SET;
				state_d = grv_pkg::ST_COL_EST;
			end
			grv_pkg::ST_COL_EST: begin
				op      = grv_pkg::OP_COL_EST;
				state_d = grv_pkg::ST_COL_FIX;
			end
			grv_pkg::ST_COL_FIX: begin
				op      = grv_pkg::OP_COL_FIX;
				state_d = grv_pkg::ST_MUL_NY;
			end
			grv_pkg::ST_MUL_NY: begin
				op      = grv_pkg::OP_MUL_NY;
				state_d = grv_pkg::ST_RND_NY;
			end
			grv_pkg::ST_RND_NY: begin
				op      = grv_pkg::OP_RND_NY;
				state_d = grv_pkg::ST_MUL_YS;
			end
			grv_pkg::ST_MUL_YS: begin
				op      = grv_pkg::OP_MUL_YS;
				state_d = grv_pkg::ST_RND_YS;
			end
			grv_pkg::ST_RND_YS: begin
				op      = grv_pkg::OP_RND_YS;
				state_d = grv_pkg::ST_STEP_A;
			end
			grv_pkg::ST_STEP_A: begin
				op      = grv_pkg::OP_STEP_A;
				state_d = st.in_bounds ? grv_pkg::ST_STEP_B : grv_pkg::ST_DONE;
			end
			grv_pkg::ST_STEP_B: begin
				op      = grv_pkg::OP_STEP_B;
				state_d = grv_pkg::ST_STEP_C;
			end
			grv_pkg::ST_STEP_C: begin
				op      = grv_pkg::OP_STEP_C;
				state_d = st.wall ? grv_pkg::ST_SQ_X : grv_pkg::ST_STEP_A;
			end
			grv_pkg::ST_SQ_X: begin
				op      = grv_pkg::OP_SQ_X;
				state_d = grv_pkg::ST_SQ_Y;
			end
			grv_pkg::ST_SQ_Y: begin
				op      = grv_pkg::OP_SQ_Y;
				state_d = grv_pkg::ST_SQ_SUM;
			end
			grv_pkg::ST_SQ_SUM: begin
				op      = grv_pkg::OP_SQ_SUM;
				state_d = grv_pkg::ST_SQRT;
			end
			grv_pkg::ST_SQRT: begin
				op = grv_pkg::OP_SQRT;
				if (st.sq_last) state_d = grv_pkg::ST_DONE;
			end
			grv_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = grv_pkg::ST_IDLE;
			end
			default: begin
				state_d = grv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/grv_dp.sv @@
module grv_dp #(
	parameter int CELL_SIZE = grv_pkg::CELL_SIZE_DEF,
	parameter int MAP_CELLS = grv_pkg::MAP_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  grv_pkg::grv_op_t              op,
	output grv_pkg::grv_status_t          st,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [grv_pkg::CfgW-1:0]      cfg_data,
	input  logic [grv_pkg::PosW-1:0]      pos_x,
	input  logic [grv_pkg::PosW-1:0]      pos_y,
	input  logic [grv_pkg::AngW-1:0]      angle,
	input  logic [grv_pkg::CellW-1:0]     cell_x,
	input  logic [grv_pkg::CellW-1:0]     cell_y,
	input  logic                          wall,
	output logic                          hit,
	output logic [grv_pkg::PosW-1:0]      hit_x,
	output logic [grv_pkg::PosW-1:0]      hit_y,
	output logic [grv_pkg::DistW-1:0]     hit_distance
);

	localparam int CellQ  = CELL_SIZE * 256;
	localparam int RecipQ = (1 << 20) / CellQ;
	localparam int RowW   = $clog2(MAP_CELLS);
	localparam int QeW    = 9;
	localparam int ColW   = 11;
	localparam int PW     = grv_pkg::PosW;
	localparam int CW     = grv_pkg::CordW;
	localparam int XW     = grv_pkg::CrdW;

	localparam logic signed [XW-1:0] CELL_STEP = XW'(CellQ);

	// registers
	logic [PW-1:0]             lim_x_q, lim_y_q, px_q, py_q;
	logic                      neg_q, force_q, right_q;
	logic [grv_pkg::CellW-1:0] wcx_q, wcy_q;
	logic                      wall_q;
	logic signed [CW-1:0]      cx_q, cy_q, cz_q;
	logic [grv_pkg::ItW-1:0]   it_q;
	logic [CW-1:0]             rem_q;
	logic [grv_pkg::QuoW-1:0]  nb_q, quo_q;
	logic                      tneg_q;
	logic signed [grv_pkg::TanW-1:0] t_q;
	logic [QeW-1:0]            qe_q;
	logic signed [XW-1:0]      nx_q, ny_q, ys_q;
	logic signed [ColW-1:0]    pcol_q;
	logic signed [grv_pkg::ProdW-1:0] prod_q;
	logic [MAP_CELLS-1:0]      rd_row_q;
	logic                      rd_vld_q, cy_ok_q, hit_q;
	logic [grv_pkg::SqW-1:0]   acc_q, sv_q, sres_q, sbit_q;
	logic [MAP_CELLS-1:0]      map_mem [MAP_CELLS];
	logic [MAP_CELLS-1:0]      row_vld_q;

	function automatic logic signed [CW-1:0] mag_shift(input logic signed [CW-1:0] v,
	                                                   input logic [grv_pkg::ItW-1:0] s);
		logic [CW-1:0] m;
		m = v[CW-1] ? CW'(-v) : CW'(v);
		m = m >> s;
		return v[CW-1] ? -$signed(m) : $signed(m);
	endfunction

	// angle decode
	logic [10:0] ang_r, ang_q11;
	logic        ang_force, ang_neg, ang_right;
	assign ang_r     = angle[10:0];
	assign ang_force = (ang_r == 11'd1024);
	assign ang_neg   = (ang_r > 11'd1024);
	assign ang_q11   = ang_neg ? 11'(12'd2048 - 12'(ang_r)) : ang_r;
	assign ang_right = (angle < 12'd1024) || (angle > 12'd3072);

	// cordic step
	logic signed [CW-1:0] c_dx, c_dy, c_at;
	assign c_dx = mag_shift(cy_q, it_q);
	assign c_dy = mag_shift(cx_q, it_q);
	assign c_at = $signed({2'b00, grv_pkg::atan_val(it_q)});

	// tan magnitude and saturation test
	logic          x_pos, t_over, tneg_d;
	logic [CW-1:0] ymag, xu;
	logic [49:0]   num;
	logic [60:0]   sat_bound;
	assign x_pos     = !cx_q[CW-1] && (cx_q != '0);
	assign ymag      = cy_q[CW-1] ? CW'(-cy_q) : CW'(cy_q);
	assign xu        = CW'(cx_q);
	assign num       = {ymag, 16'b0};
	assign sat_bound = {xu, 27'b0} + 61'(xu);
	assign t_over    = 61'(num) >= sat_bound;
	assign tneg_d    = !force_q && (neg_q ^ (x_pos && cy_q[CW-1]));

	// restoring divide, one quotient bit per cycle
	logic [CW:0]   d_r2;
	logic          d_ge;
	assign d_r2 = {rem_q, nb_q[grv_pkg::QuoW-1]};
	assign d_ge = d_r2 >= {1'b0, xu};

	// divide by the cell width: reciprocal estimate, then one correction
	logic [PW-1:0]        rc_in;
	logic [28:0]          rc_p;
	logic signed [XW-1:0] qbase, qrem;
	logic                 qcorr;
	logic [QeW:0]         cyv;
	assign rc_in = (op == grv_pkg::OP_COL_EST) ? px_q : ny_q[PW-1:0];
	assign rc_p  = 29'(rc_in) * 29'(RecipQ);
	assign qbase = XW'(qe_q) * CELL_STEP;
	assign qrem  = ((op == grv_pkg::OP_COL_FIX) ? $signed(XW'(px_q)) : ny_q) - qbase;
	assign qcorr = qrem >= CELL_STEP;
	assign cyv   = (QeW+1)'(qe_q) + (QeW+1)'(qcorr);

	// shared multiplier
	logic signed [grv_pkg::MulAW-1:0] m_a;
	logic signed [grv_pkg::MulBW-1:0] m_b;
	logic signed [XW-1:0]             dxs, dys;
	logic [PW-1:0]                    dxa, dya;
	assign dxs = nx_q - $signed(XW'(px_q));
	assign dys = ny_q - $signed(XW'(py_q));
	assign dxa = dxs[XW-1] ? PW'(-dxs) : PW'(dxs);
	assign dya = dys[XW-1] ? PW'(-dys) : PW'(dys);

	always_comb begin
		m_a = '0;
		m_b = '0;
		case (op)
			grv_pkg::OP_MUL_NY: begin
				m_a = grv_pkg::MulAW'(dxs);
				m_b = grv_pkg::MulBW'(t_q);
			end
			grv_pkg::OP_MUL_YS: begin
				m_a = right_q ? grv_pkg::MulAW'(CELL_STEP) : grv_pkg::MulAW'(-CELL_STEP);
				m_b = grv_pkg::MulBW'(t_q);
			end
			grv_pkg::OP_SQ_X: begin
				m_a = $signed(grv_pkg::MulAW'(dxa));
				m_b = $signed(grv_pkg::MulBW'(dxa));
			end
			grv_pkg::OP_SQ_Y: begin
				m_a = $signed(grv_pkg::MulAW'(dya));
				m_b = $signed(grv_pkg::MulBW'(dya));
			end
			default: begin
				m_a = '0;
				m_b = '0;
			end
		endcase
	end

	// Q24 -> Q8, nearest, ties away from zero
	logic [grv_pkg::ProdW-1:0] pmag, pinc;
	logic signed [XW-1:0]      rnd;
	assign pmag = prod_q[grv_pkg::ProdW-1] ? grv_pkg::ProdW'(-prod_q)
	                                       : grv_pkg::ProdW'(prod_q);
	assign pinc = (pmag + grv_pkg::ProdW'(32768)) >> 16;
	assign rnd  = prod_q[grv_pkg::ProdW-1] ? -$signed(XW'(pinc)) : $signed(XW'(pinc));

	// walk
	logic signed [XW-1:0]   x_step;
	logic                   in_b, col_out, wall_d;
	logic [RowW-1:0]        pidx, rd_addr;
	logic [6:0]             wcy_ext, wcx_ext;
	logic [MAP_CELLS-1:0]   wr_row;
	assign x_step  = right_q ? CELL_STEP : -CELL_STEP;
	assign in_b    = !nx_q[XW-1] && (nx_q <= $signed(XW'(lim_x_q)))
	              && !ny_q[XW-1] && (ny_q <= $signed(XW'(lim_y_q)));
	assign col_out = pcol_q[ColW-1] || (pcol_q >= $signed(ColW'(MAP_CELLS)));
	assign pidx    = pcol_q[RowW-1:0];
	assign wall_d  = !cy_ok_q || col_out || (rd_vld_q && rd_row_q[pidx]);
	assign wcy_ext = 7'(wcy_q);
	assign wcx_ext = 7'(wcx_q);
	assign rd_addr = (op == grv_pkg::OP_WR_RD) ? wcy_ext[RowW-1:0] : cyv[RowW-1:0];

	always_comb begin
		wr_row = rd_vld_q ? rd_row_q : '0;
		wr_row[wcx_ext[RowW-1:0]] = wall_q;
	end

	// integer square root step
	logic [grv_pkg::SqW-1:0] s_try;
	assign s_try = sres_q + sbit_q;

	always_comb begin
		st.wr_ok     = (int'(cell_x) < MAP_CELLS) && (int'(cell_y) < MAP_CELLS);
		st.it_last   = ((op == grv_pkg::OP_CORDIC) && (it_q == grv_pkg::CORDIC_LAST))
		            || ((op == grv_pkg::OP_DIV) && (it_q == grv_pkg::DIV_LAST));
		st.tan_sat   = force_q || !x_pos || t_over;
		st.in_bounds = in_b;
		st.wall      = wall_d;
		st.sq_last   = sbit_q[0];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q <= '1;
			lim_y_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				grv_pkg::REG_LIMIT_X: lim_x_q <= cfg_data;
				grv_pkg::REG_LIMIT_Y: lim_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// row valid bits stand in for clearing the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (op == grv_pkg::OP_WR_WR) begin
			row_vld_q[wcy_ext[RowW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (op == grv_pkg::OP_WR_WR) begin
			map_mem[wcy_ext[RowW-1:0]] <= wr_row;
		end
		if (op == grv_pkg::OP_WR_RD || op == grv_pkg::OP_STEP_B) begin
			rd_row_q <= map_mem[rd_addr];
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			grv_pkg::OP_IDLE: begin
				px_q    <= pos_x;
				py_q    <= pos_y;
				neg_q   <= ang_neg;
				force_q <= ang_force;
				right_q <= ang_right;
				wcx_q   <= cell_x;
				wcy_q   <= cell_y;
				wall_q  <= wall;
				cx_q    <= CW'(1) <<< 30;
				cy_q    <= '0;
				cz_q    <= $signed(CW'({ang_q11[9:0], 20'b0}));
				it_q    <= '0;
				hit_q   <= 1'b0;
			end
			grv_pkg::OP_CORDIC: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - c_dx;
					cy_q <= cy_q + c_dy;
					cz_q <= cz_q - c_at;
				end else begin
					cx_q <= cx_q + c_dx;
					cy_q <= cy_q - c_dy;
					cz_q <= cz_q + c_at;
				end
				it_q <= it_q + 1'b1;
			end
			grv_pkg::OP_TAN_CHK: begin
				rem_q  <= CW'(num[49:grv_pkg::QuoW]);
				nb_q   <= num[grv_pkg::QuoW-1:0];
				it_q   <= '0;
				tneg_q <= tneg_d;
				t_q    <= tneg_d ? -grv_pkg::TAN_LIM : grv_pkg::TAN_LIM;
			end
			grv_pkg::OP_DIV: begin
				rem_q <= d_ge ? CW'(d_r2 - {1'b0, xu}) : CW'(d_r2);
				nb_q  <= {nb_q[grv_pkg::QuoW-2:0], 1'b0};
				quo_q <= {quo_q[grv_pkg::QuoW-2:0], d_ge};
				it_q  <= it_q + 1'b1;
			end
			grv_pkg::OP_TAN_SET: begin
				t_q <= tneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
			grv_pkg::OP_COL_EST: begin
				qe_q <= rc_p[28:20];
			end
			grv_pkg::OP_COL_FIX: begin
				nx_q   <= qbase + (qcorr ? CELL_STEP : '0) + (right_q ? CELL_STEP : '0);
				pcol_q <= ColW'(qe_q) + ColW'(qcorr)
				        + (right_q ? ColW'(1) : -ColW'(1));
			end
			grv_pkg::OP_MUL_NY, grv_pkg::OP_MUL_YS, grv_pkg::OP_SQ_X: begin
				prod_q <= m_a * m_b;
			end
			grv_pkg::OP_RND_NY: begin
				ny_q <= $signed(XW'(py_q)) + rnd;
			end
			grv_pkg::OP_RND_YS: begin
				ys_q <= rnd;
			end
			grv_pkg::OP_STEP_A: begin
				qe_q <= rc_p[28:20];
			end
			grv_pkg::OP_STEP_B: begin
				cy_ok_q <= int'(cyv) < MAP_CELLS;
			end
			grv_pkg::OP_STEP_C: begin
				if (wall_d) begin
					hit_q <= 1'b1;
				end else begin
					nx_q   <= nx_q + x_step;
					ny_q   <= ny_q + ys_q;
					pcol_q <= pcol_q + (right_q ? ColW'(1) : -ColW'(1));
				end
			end
			grv_pkg::OP_SQ_Y: begin
				acc_q  <= grv_pkg::SqW'(prod_q);
				prod_q <= m_a * m_b;
			end
			grv_pkg::OP_SQ_SUM: begin
				sv_q   <= acc_q + grv_pkg::SqW'(prod_q);
				sres_q <= '0;
				sbit_q <= grv_pkg::SqW'(1) << 38;
			end
			grv_pkg::OP_SQRT: begin
				if (sv_q >= s_try) begin
					sv_q   <= sv_q - s_try;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			default: ;
		endcase
	end

	assign hit          = hit_q;
	assign hit_x        = hit_q ? nx_q[PW-1:0] : '0;
	assign hit_y        = hit_q ? ny_q[PW-1:0] : '0;
	assign hit_distance = !hit_q ? '0
	                    : (|sres_q[grv_pkg::SqW-1:grv_pkg::DistW]) ? '1
	                    : sres_q[grv_pkg::DistW-1:0];

endmodule
